FILE: sv/fisr_pkg.sv
// Shared constants, flag types and leading-zero helpers for the reciprocal square root block.
package fisr_pkg;

   // Bit-level initial guess and result constants.
   localparam logic [31:0] MAGIC_GUESS     = 32'h5F3759DF;
   localparam logic [31:0] CANON_NAN       = 32'h7FC00000;
   localparam logic [31:0] FP_HALF         = 32'h3F000000;
   localparam logic [31:0] FP_THREE_HALVES = 32'h3FC00000;

   // Register stages of the arithmetic units.
   localparam int FMUL_LAT   = 3;
   localparam int FADD_LAT   = 4;
   localparam int NEWTON_LAT = 3 * FMUL_LAT + FADD_LAT;

   // Special-operand summary carried down a float unit.
   typedef struct packed {
      logic nan;
      logic inf;
      logic zero;
      logic sign;
   } special_type;

   // Leading zeros of a 24-bit mantissa; 24 when it is zero.
   function automatic logic [4:0] lzc24(input logic [23:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd24;
      found = 1'b0;
      for (int i = 23; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(23 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

   // Leading zeros of a 27-bit sum; 27 when it is zero.
   function automatic logic [4:0] lzc27(input logic [26:0] v);
      logic [4:0] n;
      logic       found;
      n     = 5'd27;
      found = 1'b0;
      for (int i = 26; i >= 0; i--) begin
         if (!found && v[i]) begin
            n     = 5'(26 - i);
            found = 1'b1;
         end
      end
      return n;
   endfunction

endpackage

FILE: sv/fisr_delay.sv
// Enabled shift line that keeps operands aligned with the arithmetic units.
module fisr_delay
#(
   parameter int WIDTH = 32,
   parameter int DEPTH = 3
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);

   logic [WIDTH-1:0] pipe_ff [DEPTH];

   // Shift one place whenever the pipeline advances.
   always_ff @(posedge clock) begin
      if (en) begin
         pipe_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   assign q = pipe_ff[DEPTH-1];

endmodule

FILE: sv/fisr_fmul.sv
// Three-stage single-precision multiplier, round to nearest even, with subnormals.
module fisr_fmul
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] p
);

   // Stage 1: unpack, classify and normalize subnormal operands.
   logic [7:0]         a_exp, b_exp;
   logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
   logic [23:0]        a_m, b_m;
   logic [4:0]         a_lz, b_lz;
   logic signed [10:0] a_e, b_e;
   special_type        spec_in;

   always_comb begin
      a_exp  = a[30:23];
      b_exp  = b[30:23];
      a_nan  = (&a_exp) && (|a[22:0]);
      b_nan  = (&b_exp) && (|b[22:0]);
      a_inf  = (&a_exp) && !(|a[22:0]);
      b_inf  = (&b_exp) && !(|b[22:0]);
      a_zero = (a_exp == 8'd0) && !(|a[22:0]);
      b_zero = (b_exp == 8'd0) && !(|b[22:0]);
      a_m    = {a_exp != 8'd0, a[22:0]};
      b_m    = {b_exp != 8'd0, b[22:0]};
      a_lz   = lzc24(a_m);
      b_lz   = lzc24(b_m);
      a_e    = $signed({3'b000, (a_exp == 8'd0) ? 8'd1 : a_exp}) - $signed({6'd0, a_lz});
      b_e    = $signed({3'b000, (b_exp == 8'd0) ? 8'd1 : b_exp}) - $signed({6'd0, b_lz});
      spec_in.nan  = a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
      spec_in.inf  = a_inf || b_inf;
      spec_in.zero = a_zero || b_zero;
      spec_in.sign = a[31] ^ b[31];
   end

   special_type        spec1_ff;
   logic [23:0]        ma1_ff, mb1_ff;
   logic signed [10:0] e1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec1_ff <= spec_in;
         ma1_ff   <= a_m << a_lz;
         mb1_ff   <= b_m << b_lz;
         e1_ff    <= a_e + b_e - 11'sd127;
      end
   end

   // Stage 2: mantissa product.
   special_type        spec2_ff;
   logic [47:0]        prod2_ff;
   logic signed [10:0] e2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec2_ff <= spec1_ff;
         prod2_ff <= ma1_ff * mb1_ff;
         e2_ff    <= e1_ff;
      end
   end

   // Stage 3: one-bit normalize, denormalize on underflow, round and pack.
   logic [47:0]        norm;
   logic signed [10:0] e_n, sh;
   logic [5:0]         shc;
   logic [95:0]        wide;
   logic [47:0]        sn;
   logic [30:0]        packed_val, rounded;
   logic               g, st, inc, ovf;
   logic [31:0]        p_in;

   always_comb begin
      norm = prod2_ff[47] ? prod2_ff : {prod2_ff[46:0], 1'b0};
      e_n  = prod2_ff[47] ? e2_ff + 11'sd1 : e2_ff;
      sh   = 11'sd1 - e_n;
      shc  = (sh > 11'sd49) ? 6'd49 : sh[5:0];
      wide = {norm, 48'd0} >> shc;
      sn   = wide[95:48];
      ovf  = (e_n >= 11'sd255);
      if (e_n >= 11'sd1) begin
         packed_val = {e_n[7:0], norm[46:24]};
         g          = norm[23];
         st         = |norm[22:0];
      end else begin
         packed_val = {8'd0, sn[46:24]};
         g          = sn[23];
         st         = (|sn[22:0]) || (|wide[47:0]);
      end
      inc     = g && (packed_val[0] || st);
      rounded = packed_val + {30'd0, inc};
      if (spec2_ff.nan) begin
         p_in = CANON_NAN;
      end else if (spec2_ff.inf || (!spec2_ff.zero && ovf)) begin
         p_in = {spec2_ff.sign, 8'hFF, 23'd0};
      end else if (spec2_ff.zero) begin
         p_in = {spec2_ff.sign, 31'd0};
      end else begin
         p_in = {spec2_ff.sign, rounded};
      end
   end

   logic [31:0] p_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff <= p_in;
      end
   end

   assign p = p_ff;

endmodule

FILE: sv/fisr_fadd.sv
// Four-stage single-precision adder, round to nearest even, with subnormals.
module fisr_fadd
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] a,
   input  logic [31:0] b,
   output logic [31:0] s
);

   // Stage 1: classify, order by magnitude and take the exponent difference.
   logic [7:0]  a_exp, b_exp;
   logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, a_big;
   logic [31:0] big, small_op;
   logic [7:0]  big_e, small_e;
   special_type spec_in;

   always_comb begin
      a_exp  = a[30:23];
      b_exp  = b[30:23];
      a_nan  = (&a_exp) && (|a[22:0]);
      b_nan  = (&b_exp) && (|b[22:0]);
      a_inf  = (&a_exp) && !(|a[22:0]);
      b_inf  = (&b_exp) && !(|b[22:0]);
      a_zero = (a[30:0] == 31'd0);
      b_zero = (b[30:0] == 31'd0);
      a_big  = (a[30:0] >= b[30:0]);
      big      = a_big ? a : b;
      small_op = a_big ? b : a;
      big_e    = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
      small_e  = (small_op[30:23] == 8'd0) ? 8'd1 : small_op[30:23];
      spec_in.nan  = a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]));
      spec_in.inf  = a_inf || b_inf;
      spec_in.zero = a_zero && b_zero;
      spec_in.sign = (a_inf || b_inf) ? (a_inf ? a[31] : b[31]) : (a[31] && b[31]);
   end

   special_type spec1_ff;
   logic        sign1_ff, sub1_ff;
   logic [7:0]  e1_ff, d1_ff;
   logic [23:0] bm1_ff, sm1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec1_ff <= spec_in;
         sign1_ff <= big[31];
         sub1_ff  <= big[31] ^ small_op[31];
         e1_ff    <= big_e;
         d1_ff    <= big_e - small_e;
         bm1_ff   <= {big[30:23] != 8'd0, big[22:0]};
         sm1_ff   <= {small_op[30:23] != 8'd0, small_op[22:0]};
      end
   end

   // Stage 2: align the smaller operand with sticky and add or subtract.
   logic [4:0]  dc;
   logic [53:0] wide;
   logic [26:0] al;
   logic [27:0] sum_in;

   always_comb begin
      dc    = (d1_ff > 8'd27) ? 5'd27 : d1_ff[4:0];
      wide  = {sm1_ff, 3'b000, 27'd0} >> dc;
      al    = wide[53:27];
      al[0] = al[0] || (|wide[26:0]);
      if (sub1_ff) begin
         sum_in = {1'b0, bm1_ff, 3'b000} - {1'b0, al};
      end else begin
         sum_in = {1'b0, bm1_ff, 3'b000} + {1'b0, al};
      end
   end

   special_type spec2_ff;
   logic        sign2_ff;
   logic [7:0]  e2_ff;
   logic [27:0] sum2_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec2_ff <= spec1_ff;
         sign2_ff <= sign1_ff;
         e2_ff    <= e1_ff;
         sum2_ff  <= sum_in;
      end
   end

   // Stage 3: normalize, stopping at the subnormal exponent.
   logic [4:0]  lz;
   logic [8:0]  lim, shn;
   logic [26:0] norm_in;
   logic [8:0]  e_in;

   always_comb begin
      lz  = lzc27(sum2_ff[26:0]);
      lim = {1'b0, e2_ff} - 9'd1;
      shn = ({4'd0, lz} < lim) ? {4'd0, lz} : lim;
      if (sum2_ff[27]) begin
         norm_in = {sum2_ff[27:2], sum2_ff[1] | sum2_ff[0]};
         e_in    = {1'b0, e2_ff} + 9'd1;
      end else begin
         norm_in = sum2_ff[26:0] << shn[4:0];
         e_in    = {1'b0, e2_ff} - shn;
      end
   end

   special_type spec3_ff;
   logic        sign3_ff, zero3_ff;
   logic [8:0]  e3_ff;
   logic [26:0] norm3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         spec3_ff <= spec2_ff;
         sign3_ff <= sign2_ff;
         zero3_ff <= (sum2_ff == 28'd0);
         e3_ff    <= e_in;
         norm3_ff <= norm_in;
      end
   end

   // Stage 4: round and pack.
   logic [30:0] packed_val, rounded;
   logic        g, st, inc, ovf;
   logic [31:0] s_in;

   always_comb begin
      packed_val = {norm3_ff[26] ? e3_ff[7:0] : 8'd0, norm3_ff[25:3]};
      g          = norm3_ff[2];
      st         = norm3_ff[1] || norm3_ff[0];
      inc        = g && (packed_val[0] || st);
      rounded    = packed_val + {30'd0, inc};
      ovf        = (e3_ff >= 9'd255);
      if (spec3_ff.nan) begin
         s_in = CANON_NAN;
      end else if (spec3_ff.inf) begin
         s_in = {spec3_ff.sign, 8'hFF, 23'd0};
      end else if (spec3_ff.zero) begin
         s_in = {spec3_ff.sign, 31'd0};
      end else if (zero3_ff) begin
         s_in = 32'd0;
      end else if (ovf) begin
         s_in = {sign3_ff, 8'hFF, 23'd0};
      end else begin
         s_in = {sign3_ff, rounded};
      end
   end

   logic [31:0] s_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff <= s_in;
      end
   end

   assign s = s_ff;

endmodule

FILE: sv/fisr_newton.sv
// One Newton refinement y * (1.5 - (half * y) * y) as a chain of float units.
module fisr_newton
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [31:0] half,
   input  logic [31:0] y,
   output logic [31:0] y_out
);

   logic [31:0] p1, p2, d, y_d3, y_d10;

   // half * y
   fisr_fmul u_p1 (.clock(clock), .en(en), .a(half), .b(y), .p(p1));

   fisr_delay #(.WIDTH(32), .DEPTH(FMUL_LAT)) u_y3 (
      .clock(clock), .en(en), .d(y), .q(y_d3)
   );

   // (half * y) * y
   fisr_fmul u_p2 (.clock(clock), .en(en), .a(p1), .b(y_d3), .p(p2));

   // 1.5 - p2, as an add of the negated product.
   fisr_fadd u_d (
      .clock(clock), .en(en), .a(FP_THREE_HALVES), .b({~p2[31], p2[30:0]}), .s(d)
   );

   fisr_delay #(.WIDTH(32), .DEPTH(FMUL_LAT + FADD_LAT)) u_y10 (
      .clock(clock), .en(en), .d(y_d3), .q(y_d10)
   );

   // y * (1.5 - p2)
   fisr_fmul u_r (.clock(clock), .en(en), .a(y_d10), .b(d), .p(y_out));

endmodule

FILE: sv/fast_inverse_sqrt.sv
// Top level: pipelined approximate reciprocal square root of a single-precision value.
//
//  Channel   Direction  Payload (low bit first)
//  req_*     in         tdata[31:0] value_bits
//  rsp_*     out        tdata[31:0] result_bits
//  csr_*     in         wr_data[1:0] newton_steps (reset 2)
//
// One transfer in per cycle while the output is not stalled, one result out per input, in order.
// The pipeline is a 3-stage halving multiply, two 13-stage Newton
// steps (three multipliers and one 4-stage adder each) and the output register.
// Reset is synchronous, clears the valid bits and sets the step count to 2.
// When the output register holds an untaken result, the whole pipeline stalls.
module fast_inverse_sqrt
   import fisr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,  // newton_steps
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] value_bits
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata     // [31:0] result_bits
);

   localparam int LAT = FMUL_LAT + 2 * NEWTON_LAT;

   logic [1:0]     steps_ff, steps_in;
   logic [LAT-1:0] vld_ff, vld_in;
   logic           rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]    rsp_tdata_ff;
   logic           adv;
   logic [31:0]    guess, half0, y0, half0_d, y1, y1_d, y2, sel, res_in;
   logic           one_d;

   // Step count register.
   assign steps_in = csr_wr_en ? csr_wr_data : steps_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= 2'd2;
      end else begin
         steps_ff <= steps_in;
      end
   end

   // Global advance: the pipeline moves whenever the output can take a result.
   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;

   // Valid bits travel alongside the data stages.
   assign vld_in = adv ? {vld_ff[LAT-2:0], req_tvalid} : vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // Front end: halving multiply and the integer initial guess.
   assign guess = MAGIC_GUESS - {req_tdata[31], req_tdata[31:1]};

   fisr_fmul u_half (.clock(clock), .en(adv), .a(req_tdata), .b(FP_HALF), .p(half0));

   fisr_delay #(.WIDTH(32), .DEPTH(FMUL_LAT)) u_guess (
      .clock(clock), .en(adv), .d(guess), .q(y0)
   );

   fisr_delay #(.WIDTH(1), .DEPTH(LAT)) u_one (
      .clock(clock), .en(adv), .d(!steps_ff[1]), .q(one_d)
   );

   // Two refinement steps; the second sees half delayed to match.
   fisr_newton u_step1 (.clock(clock), .en(adv), .half(half0), .y(y0), .y_out(y1));

   fisr_delay #(.WIDTH(32), .DEPTH(NEWTON_LAT)) u_half_d (
      .clock(clock), .en(adv), .d(half0), .q(half0_d)
   );

   fisr_newton u_step2 (.clock(clock), .en(adv), .half(half0_d), .y(y1), .y_out(y2));

   fisr_delay #(.WIDTH(32), .DEPTH(NEWTON_LAT)) u_y1_d (
      .clock(clock), .en(adv), .d(y1), .q(y1_d)
   );

   // Select by step count and make every NaN canonical.
   always_comb begin
      sel = one_d ? y1_d : y2;
      if ((&sel[30:23]) && (|sel[22:0])) begin
         res_in = CANON_NAN;
      end else begin
         res_in = sel;
      end
   end

   // Output register.
   assign rsp_tvalid_in = adv ? vld_ff[LAT-1] : rsp_tvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= res_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // A stalled result blocks new transfers.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |-> !req_tready)
      else $error("input accepted while output stalled");

   // An accepted transfer enters the first valid stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> vld_ff[0])
      else $error("accepted transfer lost at pipeline entry");

   // The last valid stage reaches the output when the pipeline advances.
   a_exit: assert property (@(posedge clock) disable iff (reset)
      (adv && vld_ff[LAT-1]) |=> rsp_tvalid)
      else $error("pipeline result lost at output");

   // Results never carry a NaN other than the canonical one.
   a_nan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !((&rsp_tdata[30:23]) && (|rsp_tdata[22:0]) && (rsp_tdata != CANON_NAN)))
      else $error("non-canonical NaN on output");

endmodule

FILE: dv/fast_inverse_sqrt_tb.sv
// Self-checking testbench for the pipelined reciprocal square root block.
`timescale 1ns / 1ps

module fast_inverse_sqrt_tb
   import fisr_pkg::*;
();

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 255;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = 2'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = 32'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   // One row of the directed table; a fixed result is used where it is obvious.
   typedef struct {
      logic [31:0] value;
      logic        fixed;
      logic [31:0] result;
   } vector_row_type;

   typedef struct {
      logic        fixed;
      logic [31:0] result;
   } send_tag_type;

   logic [31:0]    pending_results[$];
   send_tag_type   sent_tags[$];
   logic [1:0]     model_steps = 2'd2;
   logic           quiet = 1'b0;
   int             error_count = 0;
   int             cycle_count = 0;
   vector_row_type vectors[20];

   fast_inverse_sqrt dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   always #10 clock = ~clock;

   // Round a value sig * 2^lsb_exp to single precision, nearest even.
   function automatic logic [31:0] fp_round(logic sgn, int lsb_exp, logic [63:0] sig);
      logic [127:0] wide, keep, rem, halfway;
      int msb, sh, bexp;
      if (sig == 64'd0) return {sgn, 31'd0};
      msb = 0;
      for (int i = 0; i < 64; i++) if (sig[i]) msb = i;
      sh = msb - 23;
      if (-149 - lsb_exp > sh) sh = -149 - lsb_exp;
      if (sh >= 100) return {sgn, 31'd0};
      wide = {64'd0, sig};
      if (sh > 0) begin
         keep    = wide >> sh;
         rem     = wide & ((128'd1 << sh) - 128'd1);
         halfway = 128'd1 << (sh - 1);
         if (rem > halfway || (rem == halfway && keep[0])) keep = keep + 128'd1;
      end else begin
         keep = wide << (-sh);
      end
      if (keep[24]) begin
         keep = keep >> 1;
         sh++;
      end
      if (!keep[23]) return {sgn, 8'd0, keep[22:0]};
      bexp = sh + lsb_exp + 23 + 127;
      if (bexp >= 255) return {sgn, 8'hFF, 23'd0};
      return {sgn, bexp[7:0], keep[22:0]};
   endfunction

   // Significand with hidden bit and the exponent of its lowest bit.
   function automatic void fp_split(input logic [31:0] a, output logic [23:0] m,
                                    output int lsb_exp);
      if (a[30:23] == 8'd0) begin
         m       = {1'b0, a[22:0]};
         lsb_exp = -149;
      end else begin
         m       = {1'b1, a[22:0]};
         lsb_exp = int'(a[30:23]) - 150;
      end
   endfunction

   function automatic logic is_nan(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] != 23'd0;
   endfunction

   function automatic logic is_inf(logic [31:0] a);
      return a[30:23] == 8'hFF && a[22:0] == 23'd0;
   endfunction

   function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
      logic        sgn;
      logic [23:0] ma, mb;
      int          ea, eb;
      sgn = a[31] ^ b[31];
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) || is_inf(b)) begin
         if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return CANON_NAN;
         return {sgn, 8'hFF, 23'd0};
      end
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      return fp_round(sgn, ea + eb, 64'(ma) * 64'(mb));
   endfunction

   function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
      logic [31:0] t;
      logic [23:0] ma, mb;
      logic [63:0] big, lit, full, sum;
      int          ea, eb, d;
      if (is_nan(a) || is_nan(b)) return CANON_NAN;
      if (is_inf(a) && is_inf(b) && a[31] != b[31]) return CANON_NAN;
      if (is_inf(a)) return a;
      if (is_inf(b)) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      if (a[30:0] < b[30:0]) begin
         t = a;
         a = b;
         b = t;
      end
      fp_split(a, ma, ea);
      fp_split(b, mb, eb);
      d    = ea - eb;
      big  = {1'b0, ma, 39'd0};
      full = {1'b0, mb, 39'd0};
      // Bits shifted out of the smaller operand fold into a sticky bit.
      if (d >= 64) begin
         lit = {63'd0, mb != 24'd0};
      end else begin
         lit = full >> d;
         if ((full & ((64'd1 << d) - 64'd1)) != 64'd0) lit[0] = 1'b1;
      end
      sum = (a[31] == b[31]) ? big + lit : big - lit;
      if (sum == 64'd0) return 32'd0;
      return fp_round(a[31], ea - 39, sum);
   endfunction

   // Expected reciprocal square root for one value at the given step count.
   function automatic logic [31:0] rsqrt_predict(logic [31:0] x, logic [1:0] steps);
      logic [31:0] half, y, p1, p2, diff;
      int          n;
      half = fp_mul(x, FP_HALF);
      y    = MAGIC_GUESS - {x[31], x[31:1]};
      n    = (steps == 2'd0) ? 1 : (steps == 2'd3) ? 2 : int'(steps);
      for (int k = 0; k < n; k++) begin
         p1   = fp_mul(half, y);
         p2   = fp_mul(p1, y);
         diff = fp_add(FP_THREE_HALVES, {~p2[31], p2[30:0]});
         y    = fp_mul(y, diff);
      end
      if (is_nan(y)) y = CANON_NAN;
      return y;
   endfunction

   // Random operand biased toward ordinary positive values.
   function automatic logic [31:0] draw_value();
      logic [31:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0, 1, 2, 3: v[31:23] = {1'b0, 8'($urandom_range(100, 160))};
         4:          v[31:23] = {1'b0, 8'($urandom_range(1, 254))};
         5:          ;
         6:          v[30:23] = 8'd0;
         7:          v[30:23] = ($urandom_range(1)) ? 8'hFF : 8'd1;
         8:          v[31:23] = {1'b1, 8'($urandom_range(100, 160))};
         default:    v[30:23] = 8'($urandom_range(200, 254));
      endcase
      return v;
   endfunction

   // Offer one value and hold it until the transfer completes.
   task automatic send_value(logic [31:0] v, logic fixed, logic [31:0] result);
      send_tag_type tag;
      while (!quiet && $urandom_range(99) < 10) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      tag.fixed  = fixed;
      tag.result = result;
      sent_tags.push_back(tag);
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Let the pipeline drain, then write the step count.
   task automatic write_steps(logic [1:0] steps);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 || sent_tags.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= steps;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // Receiver stalls at random except in the quiet stretch.
   always @(negedge clock) begin
      rsp_tready <= quiet || ($urandom_range(99) >= 10);
   end

   // Track configuration, predict on each input transfer, check each output transfer.
   always @(posedge clock) begin
      send_tag_type tag;
      logic [31:0]  want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t timeout after %0d cycles", $time, cycle_count);
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset) begin
         if (csr_wr_en) model_steps = csr_wr_data;
         if (req_tvalid && req_tready) begin
            tag = sent_tags.pop_front();
            pending_results.push_back(tag.fixed ? tag.result
                                                : rsqrt_predict(req_tdata, model_steps));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               $display("%0t unexpected result: expected none, actual %h", $time, rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_tdata !== want) begin
                  $display("%0t result_bits mismatch: expected %h, actual %h",
                           $time, want, rsp_tdata);
                  error_count++;
               end
            end
         end
      end
   end

   initial begin
      logic [1:0] phase_steps[6];
      // Specials, extremes and ordinary values; NaN inputs always give the canonical NaN.
      vectors = '{
         '{32'h0000_0000, 1'b0, 32'd0}, '{32'h8000_0000, 1'b0, 32'd0},
         '{32'h7F80_0000, 1'b0, 32'd0}, '{32'hFF80_0000, 1'b0, 32'd0},
         '{32'h7FC0_0000, 1'b1, CANON_NAN}, '{32'h7F80_0001, 1'b1, CANON_NAN},
         '{32'hFFFF_FFFF, 1'b1, CANON_NAN}, '{32'hFFC0_0000, 1'b1, CANON_NAN},
         '{32'h0000_0001, 1'b0, 32'd0}, '{32'h007F_FFFF, 1'b0, 32'd0},
         '{32'h0080_0000, 1'b0, 32'd0}, '{32'h7F7F_FFFF, 1'b0, 32'd0},
         '{32'h3F80_0000, 1'b0, 32'd0}, '{32'h4080_0000, 1'b0, 32'd0},
         '{32'h3E80_0000, 1'b0, 32'd0}, '{32'h4000_0000, 1'b0, 32'd0},
         '{32'hBF80_0000, 1'b0, 32'd0}, '{32'h8000_0001, 1'b0, 32'd0},
         '{32'h5555_5555, 1'b0, 32'd0}, '{32'h2AAA_AAAA, 1'b0, 32'd0}
      };
      phase_steps = '{2'd2, 2'd1, 2'd0, 2'd3, 2'd2, 2'd1};

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first phase runs on the reset step count; later phases write it.
      for (int p = 0; p < 6; p++) begin
         if (p != 0) write_steps(phase_steps[p]);
         foreach (vectors[i]) send_value(vectors[i].value, vectors[i].fixed, vectors[i].result);
         for (int i = 0; i < RANDOM_ITEMS; i++) begin
            quiet = (p == 2 && i >= 50 && i < 250);
            send_value(draw_value(), 1'b0, 32'd0);
         end
         quiet = 1'b0;
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0 || sent_tags.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (pending_results.size() != 0) error_count++;

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
